// File: hdl/bfha_pkg.sv
package bfha_pkg;

    // Heap geometry
    localparam int HEAP_UNITS = 4096;
    localparam int IW         = $clog2(HEAP_UNITS + 2);
    localparam int SW         = 13;

    typedef logic [IW-1:0] idx_t;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSPC  = 2'd1;
    localparam logic [1:0] ST_BADADR = 2'd2;
    localparam logic [1:0] ST_DBLFRE = 2'd3;

    // Memory select codes
    localparam logic [2:0] M_SIZE  = 3'd0;
    localparam logic [2:0] M_FREE  = 3'd1;
    localparam logic [2:0] M_BPREV = 3'd2;
    localparam logic [2:0] M_LPREV = 3'd3;
    localparam logic [2:0] M_LNEXT = 3'd4;

    // One access from the sequencer to the block store
    typedef struct packed {
        logic       we;
        logic [2:0] sel;
        idx_t       addr;
        logic [SW-1:0] wdata;
    } mem_req_t;

endpackage

// File: hdl/bfha_if.sv
interface bfha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] alloc_bytes;
    logic [14:0] free_offset;
    modport source (output valid, command, alloc_bytes, free_offset, input ready);
    modport sink   (input valid, command, alloc_bytes, free_offset, output ready);
endinterface

interface bfha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] alloc_offset;
    modport source (output valid, status, alloc_offset, input ready);
    modport sink   (input valid, status, alloc_offset, output ready);
endinterface

interface bfha_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/bfha_store.sv
module bfha_store
    import bfha_pkg::*;
(
    input  logic          clk,
    input  mem_req_t      req,
    output logic [SW-1:0] rdata
);

    // Block header and list link memories; index 0 and out of range act as "none"
    localparam int DEPTH = HEAP_UNITS + 1;

    logic [SW-1:0] size_mem  [DEPTH];
    logic          free_mem  [DEPTH];
    logic [SW-1:0] bprev_mem [DEPTH];
    logic [SW-1:0] lprev_mem [DEPTH];
    logic [SW-1:0] lnext_mem [DEPTH];

    logic in_rng;
    assign in_rng = (req.addr >= IW'(1)) && (req.addr <= IW'(HEAP_UNITS));

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (req.we && in_rng)
        begin
            case (req.sel)
                M_SIZE:  size_mem[req.addr]  <= req.wdata;
                M_FREE:  free_mem[req.addr]  <= req.wdata[0];
                M_BPREV: bprev_mem[req.addr] <= req.wdata;
                M_LPREV: lprev_mem[req.addr] <= req.wdata;
                M_LNEXT: lnext_mem[req.addr] <= req.wdata;
                default: ;
            endcase
        end
    end

    // Registered read; address 0 reads as zero
    always_ff @(posedge clk)
    begin
        if (!in_rng)
            rdata <= '0;
        else
        begin
            case (req.sel)
                M_SIZE:  rdata <= size_mem[req.addr];
                M_FREE:  rdata <= {{(SW-1){1'b0}}, free_mem[req.addr]};
                M_BPREV: rdata <= bprev_mem[req.addr];
                M_LPREV: rdata <= lprev_mem[req.addr];
                M_LNEXT: rdata <= lnext_mem[req.addr];
                default: rdata <= '0;
            endcase
        end
    end

endmodule

// File: hdl/best_fit_heap_allocator.sv
// Channel | Dir | Payload                              | Transfer
// req     | in  | command, alloc_bytes, free_offset    | valid & ready
// rsp     | out | status, alloc_offset                 | valid & ready
// cfg     | in  | data (heap_units)                    | valid & ready
// A request's time from its transfer to a valid response grows with each free-list entry
// that an alloc or insert walk steps past; the single-port header store
// (one access per cycle, read data registered) sets that.
// Reset and a heap_units write set up the spanning free block.
// req.ready is low while a request runs, until its response is transferred,
// and while cfg.valid is high.
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bfha_req_if.sink    req,
    bfha_rsp_if.source  rsp,
    bfha_cfg_if.sink    cfg
);

    localparam logic [5:0]
        S_IDLE=6'd0,  S_INIT=6'd1,  S_RSP=6'd2,
        S_AW0=6'd3,   S_AW1=6'd4,   S_AW2=6'd5,   S_AW3=6'd6,
        S_AFND=6'd7,  S_AS0=6'd8,   S_AS1=6'd9,   S_AS2=6'd10,  S_AS3=6'd11,
        S_AS4=6'd12,  S_FR0=6'd13,  S_FR1=6'd14,  S_FR2=6'd15,  S_FR3=6'd16,
        S_FR4=6'd17,  S_FR5=6'd18,  S_FR6=6'd19,  S_FR7=6'd20,  S_FR8=6'd21,
        S_FR9=6'd22,  S_FN0=6'd23,  S_FN1=6'd24,  S_FN2=6'd25,  S_FN3=6'd26,
        S_FN4=6'd27,  S_FN5=6'd28,  S_RM0=6'd29,  S_RM1=6'd30,  S_RM2=6'd31,
        S_RM3=6'd32,  S_RM4=6'd33,  S_RM5=6'd34,  S_IN0=6'd35,  S_IN1=6'd36,
        S_IN2=6'd37,  S_IN3=6'd38,  S_IN4=6'd39,  S_IN5=6'd40,  S_IN6=6'd41,
        S_IN7=6'd42,  S_IN8=6'd43,  S_IN9=6'd44,  S_IN10=6'd45, S_AFIN=6'd46,
        S_I0=6'd47;

    // Subroutine return points
    localparam logic [2:0] R_INIT=3'd0, R_ASPL=3'd1, R_DONE=3'd2, R_FPV=3'd3, R_FNX=3'd4;

    logic [5:0]  st_reg, st_next;
    logic [2:0]  ret_reg, ret_next, rret_reg, rret_next;
    logic [12:0] hu_reg, hu_next;
    idx_t        head_reg, head_next, tail_reg, tail_next;
    idx_t        idx_reg, idx_next, cur_reg, cur_next;
    idx_t        a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [SW:0] want_reg, want_next;
    logic [SW-1:0] sz_reg, sz_next, t_reg, t_next;
    logic [IW:0] steps_reg, steps_next;
    logic [1:0]  stat_reg, stat_next;
    logic [14:0] off_reg, off_next;
    logic [12:0] sat;

    mem_req_t      mreq;
    logic [SW-1:0] rdata;
    idx_t          rd_i;

    bfha_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

    assign rd_i      = IW'(rdata);
    assign req.ready = (st_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (st_reg == S_IDLE);
    assign rsp.valid = (st_reg == S_RSP);
    assign rsp.status       = stat_reg;
    assign rsp.alloc_offset = off_reg;

    assign sat = (cfg.data < 13'd3) ? 13'd3 :
                 (cfg.data > 13'(HEAP_UNITS)) ? 13'(HEAP_UNITS) : cfg.data;

    // Sequencer
    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg; rret_next = rret_reg; hu_next = hu_reg;
        head_next = head_reg; tail_next = tail_reg; idx_next = idx_reg; cur_next = cur_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; want_next = want_reg;
        sz_next = sz_reg; t_next = t_reg; steps_next = steps_reg;
        stat_next = stat_reg; off_next = off_reg;
        mreq = '{we:1'b0, sel:M_SIZE, addr:'0, wdata:'0};
        case (st_reg)
            S_IDLE:
            begin
                if (cfg.valid)
                begin
                    hu_next = sat;
                    st_next = S_I0;
                end
                else if (req.valid)
                begin
                    stat_next = ST_OK;
                    off_next = '0;
                    if (req.command == CMD_ALLOC)
                    begin
                        want_next = (SW+1)'((17'(req.alloc_bytes) + 17'd7) >> 3);
                        idx_next = head_reg;
                        steps_next = '0;
                        st_next = S_AW0;
                    end
                    else if (req.free_offset[2:0] != 3'd0 || req.free_offset == 15'd0 ||
                             16'(req.free_offset) >= {hu_reg, 3'b000})
                    begin
                        stat_next = ST_BADADR;
                        st_next = S_RSP;
                    end
                    else
                    begin
                        idx_next = IW'(req.free_offset[14:3]);
                        st_next = S_FR0;
                    end
                end
            end
            // Heap setup: size, back link, then insert at index 1
            S_I0:
            begin
                mreq = '{we:1'b1, sel:M_SIZE, addr:IW'(1), wdata:hu_reg - 13'd1};
                head_next = '0; tail_next = '0;
                st_next = S_INIT;
            end
            S_INIT:
            begin
                mreq = '{we:1'b1, sel:M_BPREV, addr:IW'(1), wdata:'0};
                cur_next = IW'(1);
                ret_next = R_INIT;
                st_next = S_IN0;
            end
            S_RSP:
                if (rsp.ready) st_next = S_IDLE;
            // Allocate: walk the sorted list for the first fit
            S_AW0:
            begin
                if (idx_reg == '0)
                begin
                    stat_next = ST_NOSPC;
                    st_next = S_RSP;
                end
                else
                begin
                    mreq = '{we:1'b0, sel:M_SIZE, addr:idx_reg, wdata:'0};
                    st_next = S_AW1;
                end
            end
            S_AW1:
            begin
                if ({1'b0, rdata} >= want_reg)
                begin
                    sz_next = rdata;
                    st_next = S_AFND;
                end
                else if (steps_reg + 1'b1 > (IW+1)'(HEAP_UNITS))
                begin
                    stat_next = ST_NOSPC;
                    st_next = S_RSP;
                end
                else
                begin
                    steps_next = steps_reg + 1'b1;
                    mreq = '{we:1'b0, sel:M_LNEXT, addr:idx_reg, wdata:'0};
                    st_next = S_AW2;
                end
            end
            S_AW2:
            begin
                idx_next = rd_i;
                st_next = S_AW0;
            end
            S_AFND:
            begin
                cur_next = idx_reg;
                rret_next = R_ASPL;
                st_next = S_RM0;
            end
            S_AS0:
            begin
                if (sz_reg - SW'(want_reg) >= 13'd2)
                begin
                    a_next = IW'(idx_reg + SW'(want_reg) + 1'b1);
                    c_next = IW'(idx_reg + sz_reg + 1'b1);
                    mreq = '{we:1'b1, sel:M_SIZE, addr:IW'(idx_reg + SW'(want_reg) + 1'b1),
                             wdata:sz_reg - SW'(want_reg) - 13'd1};
                    st_next = S_AS1;
                end
                else
                    st_next = S_AFIN;
            end
            S_AS1:
            begin
                mreq = '{we:1'b1, sel:M_BPREV, addr:a_reg, wdata:SW'(idx_reg)};
                st_next = S_AS2;
            end
            S_AS2:
            begin
                mreq = '{we:1'b1, sel:M_SIZE, addr:idx_reg, wdata:SW'(want_reg)};
                cur_next = a_reg;
                ret_next = R_ASPL;
                st_next = S_IN0;
            end
            S_AS3:
            begin
                if ((IW+1)'(c_reg) < (IW+1)'(hu_reg) + 1'b1)
                    mreq = '{we:1'b1, sel:M_BPREV, addr:c_reg, wdata:SW'(cur_reg)};
                st_next = S_AFIN;
            end
            S_AFIN:
            begin
                off_next = 15'({idx_reg, 3'b000});
                st_next = S_RSP;
            end
            // Free: check mark, find next, try merging
            S_FR0:
            begin
                mreq = '{we:1'b0, sel:M_FREE, addr:idx_reg, wdata:'0};
                st_next = S_FR1;
            end
            S_FR1:
            begin
                if (rdata[0])
                begin
                    stat_next = ST_DBLFRE;
                    st_next = S_RSP;
                end
                else
                begin
                    mreq = '{we:1'b0, sel:M_SIZE, addr:idx_reg, wdata:'0};
                    st_next = S_FR2;
                end
            end
            S_FR2:
            begin
                sz_next = rdata;
                c_next = IW'(idx_reg + rdata + 1'b1);
                if (idx_reg > IW'(1))
                begin
                    mreq = '{we:1'b0, sel:M_BPREV, addr:idx_reg, wdata:'0};
                    st_next = S_FR3;
                end
                else
                    st_next = S_FN0;
            end
            S_FR3:
            begin
                a_next = rd_i;
                mreq = '{we:1'b0, sel:M_FREE, addr:rd_i, wdata:'0};
                st_next = S_FR4;
            end
            S_FR4:
            begin
                if (rdata[0])
                begin
                    cur_next = a_reg;
                    rret_next = R_FPV;
                    st_next = S_RM0;
                end
                else
                    st_next = S_FN0;
            end
            S_FR5:
            begin
                mreq = '{we:1'b0, sel:M_SIZE, addr:cur_reg, wdata:'0};
                st_next = S_FR6;
            end
            S_FR6:
            begin
                mreq = '{we:1'b1, sel:M_SIZE, addr:cur_reg, wdata:rdata + sz_reg + 13'd1};
                st_next = S_FR7;
            end
            S_FR7:
            begin
                if ((IW+1)'(c_reg) < (IW+1)'(hu_reg) + 1'b1)
                    mreq = '{we:1'b1, sel:M_BPREV, addr:c_reg, wdata:SW'(cur_reg)};
                idx_next = cur_reg;
                st_next = S_FN0;
            end
            S_FR8, S_FR9:
                st_next = S_FN0;
            S_FN0:
            begin
                if ((IW+1)'(c_reg) < (IW+1)'(hu_reg) + 1'b1)
                begin
                    mreq = '{we:1'b0, sel:M_FREE, addr:c_reg, wdata:'0};
                    st_next = S_FN1;
                end
                else
                    st_next = S_FN5;
            end
            S_FN1:
            begin
                if (rdata[0])
                begin
                    cur_next = c_reg;
                    rret_next = R_FNX;
                    st_next = S_RM0;
                end
                else
                    st_next = S_FN5;
            end
            S_FN2:
            begin
                mreq = '{we:1'b0, sel:M_SIZE, addr:idx_reg, wdata:'0};
                st_next = S_FN3;
            end
            S_FN3:
            begin
                t_next = rdata;
                mreq = '{we:1'b0, sel:M_SIZE, addr:c_reg, wdata:'0};
                st_next = S_FN4;
            end
            S_FN4:
            begin
                mreq = '{we:1'b1, sel:M_SIZE, addr:idx_reg, wdata:t_reg + rdata + 13'd1};
                b_next = IW'(idx_reg + t_reg + rdata + 13'd2);
                st_next = S_AS4;
            end
            S_AS4:
            begin
                if ((IW+1)'(b_reg) < (IW+1)'(hu_reg) + 1'b1)
                    mreq = '{we:1'b1, sel:M_BPREV, addr:b_reg, wdata:SW'(idx_reg)};
                st_next = S_FN5;
            end
            S_FN5:
            begin
                cur_next = idx_reg;
                ret_next = R_DONE;
                st_next = S_IN0;
            end
            // List remove of cur
            S_RM0:
            begin
                mreq = '{we:1'b0, sel:M_LPREV, addr:cur_reg, wdata:'0};
                st_next = S_RM1;
            end
            S_RM1:
            begin
                a_next = rd_i;
                mreq = '{we:1'b0, sel:M_LNEXT, addr:cur_reg, wdata:'0};
                st_next = S_RM2;
            end
            S_RM2:
            begin
                b_next = rd_i;
                if (a_reg != '0)
                    mreq = '{we:1'b1, sel:M_LNEXT, addr:a_reg, wdata:rdata};
                else
                    head_next = rd_i;
                st_next = S_RM3;
            end
            S_RM3:
            begin
                if (b_reg != '0)
                    mreq = '{we:1'b1, sel:M_LPREV, addr:b_reg, wdata:SW'(a_reg)};
                else
                    tail_next = a_reg;
                st_next = S_RM4;
            end
            S_RM4:
            begin
                mreq = '{we:1'b1, sel:M_FREE, addr:cur_reg, wdata:'0};
                st_next = S_RM5;
            end
            S_RM5:
            begin
                case (rret_reg)
                    R_ASPL: st_next = S_AS0;
                    R_FPV:  st_next = S_FR5;
                    default: st_next = S_FN2;
                endcase
            end
            // List insert of cur, sorted by size
            S_IN0:
            begin
                mreq = '{we:1'b0, sel:M_SIZE, addr:cur_reg, wdata:'0};
                b_next = head_reg;
                steps_next = '0;
                st_next = S_IN1;
            end
            S_IN1:
            begin
                t_next = rdata;
                st_next = S_IN2;
            end
            S_IN2:
            begin
                if (b_reg == '0)
                    st_next = S_IN5;
                else if (steps_reg > (IW+1)'(HEAP_UNITS))
                begin
                    b_next = '0;
                    st_next = S_IN5;
                end
                else
                begin
                    mreq = '{we:1'b0, sel:M_SIZE, addr:b_reg, wdata:'0};
                    st_next = S_IN3;
                end
            end
            S_IN3:
            begin
                if (t_reg > rdata)
                begin
                    mreq = '{we:1'b0, sel:M_LNEXT, addr:b_reg, wdata:'0};
                    st_next = S_IN4;
                end
                else
                    st_next = S_IN5;
            end
            S_IN4:
            begin
                b_next = rd_i;
                steps_next = steps_reg + 1'b1;
                st_next = S_IN2;
            end
            S_IN5:
            begin
                if (b_reg != '0)
                begin
                    mreq = '{we:1'b0, sel:M_LPREV, addr:b_reg, wdata:'0};
                    st_next = S_IN6;
                end
                else
                begin
                    a_next = tail_reg;
                    tail_next = cur_reg;
                    st_next = S_IN7;
                end
            end
            S_IN6:
            begin
                a_next = rd_i;
                mreq = '{we:1'b1, sel:M_LPREV, addr:b_reg, wdata:SW'(cur_reg)};
                st_next = S_IN7;
            end
            S_IN7:
            begin
                if (a_reg != '0)
                    mreq = '{we:1'b1, sel:M_LNEXT, addr:a_reg, wdata:SW'(cur_reg)};
                else
                    head_next = cur_reg;
                st_next = S_IN8;
            end
            S_IN8:
            begin
                mreq = '{we:1'b1, sel:M_LPREV, addr:cur_reg, wdata:SW'(a_reg)};
                st_next = S_IN9;
            end
            S_IN9:
            begin
                mreq = '{we:1'b1, sel:M_LNEXT, addr:cur_reg, wdata:SW'(b_reg)};
                st_next = S_IN10;
            end
            S_IN10:
            begin
                mreq = '{we:1'b1, sel:M_FREE, addr:cur_reg, wdata:SW'(1)};
                case (ret_reg)
                    R_INIT: st_next = S_IDLE;
                    R_ASPL: st_next = S_AS3;
                    default: st_next = S_RSP;
                endcase
            end
            default: st_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_I0;
            hu_reg   <= 13'(HEAP_UNITS);
            head_reg <= '0;
            tail_reg <= '0;
            ret_reg  <= R_INIT;
            rret_reg <= R_ASPL;
        end
        else
        begin
            st_reg   <= st_next;
            hu_reg   <= hu_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            ret_reg  <= ret_next;
            rret_reg <= rret_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; cur_reg <= cur_next; a_reg <= a_next; b_reg <= b_next;
        c_reg <= c_next; want_reg <= want_next; sz_reg <= sz_next; t_reg <= t_next;
        steps_reg <= steps_next; stat_reg <= stat_next; off_reg <= off_next;
    end

endmodule

// File: test/best_fit_heap_allocator_test.sv
`timescale 1ns / 100ps

module best_fit_heap_allocator_test;
    import bfha_pkg::*;

    localparam int CYCLE_LIMIT = 60000000;
    localparam int STORE_LAST  = HEAP_UNITS + 1;

    typedef struct {
        logic [1:0]  status;
        logic [14:0] alloc_offset;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bfha_req_if req ();
    bfha_rsp_if rsp ();
    bfha_cfg_if cfg ();

    best_fit_heap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // Shadow heap state
    int unsigned blk_size [0:STORE_LAST];
    bit          blk_free [0:STORE_LAST];
    int unsigned blk_prev [0:STORE_LAST];
    int unsigned fl_prev  [0:STORE_LAST];
    int unsigned fl_next  [0:STORE_LAST];
    int unsigned fl_head;
    int unsigned fl_tail;
    int unsigned heap_size;
    int unsigned heap_end;

    reply_t pending_replies [$];
    int unsigned live_offsets [$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    always #1 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned rd_idx(int unsigned i);
        return (i >= 1 && i <= HEAP_UNITS) ? i : 0;
    endfunction

    function automatic int unsigned wr_idx(int unsigned i);
        return (i >= 1 && i <= HEAP_UNITS) ? i : STORE_LAST;
    endfunction

    // Link a block into the free list, ordered by size
    function automatic void free_list_insert(int unsigned idx);
        int unsigned sz;
        int unsigned nx;
        int unsigned pv;
        int unsigned steps;
        sz = blk_size[rd_idx(idx)];
        nx = fl_head;
        steps = 0;
        while (nx != 0 && steps <= HEAP_UNITS && sz > blk_size[rd_idx(nx)])
        begin
            nx = fl_next[rd_idx(nx)];
            steps++;
        end
        if (steps > HEAP_UNITS)
            nx = 0;
        if (nx != 0)
        begin
            pv = fl_prev[rd_idx(nx)];
            fl_prev[wr_idx(nx)] = idx;
        end
        else
        begin
            pv = fl_tail;
            fl_tail = idx;
        end
        if (pv != 0)
            fl_next[wr_idx(pv)] = idx;
        else
            fl_head = idx;
        fl_prev[wr_idx(idx)] = pv;
        fl_next[wr_idx(idx)] = nx;
        blk_free[wr_idx(idx)] = 1'b1;
    endfunction

    function automatic void free_list_remove(int unsigned idx);
        int unsigned pv;
        int unsigned nx;
        pv = fl_prev[rd_idx(idx)];
        nx = fl_next[rd_idx(idx)];
        if (pv != 0)
            fl_next[wr_idx(pv)] = nx;
        else
            fl_head = nx;
        if (nx != 0)
            fl_prev[wr_idx(nx)] = pv;
        else
            fl_tail = pv;
        blk_free[wr_idx(idx)] = 1'b0;
    endfunction

    // Rebuild one spanning free block
    function automatic void heap_format(int unsigned value);
        int unsigned v;
        v = value & 32'h1FFF;
        if (v < 3)
            v = 3;
        if (v > HEAP_UNITS)
            v = HEAP_UNITS;
        heap_size = v;
        heap_end = v + 1;
        fl_head = 0;
        fl_tail = 0;
        blk_size[wr_idx(1)] = v - 1;
        blk_prev[wr_idx(1)] = 0;
        free_list_insert(1);
    endfunction

    function automatic reply_t best_fit_alloc(int unsigned bytes);
        reply_t r;
        int unsigned want;
        int unsigned idx;
        int unsigned steps;
        int unsigned cur;
        int unsigned rest;
        int unsigned after;
        want = (bytes + 7) / 8;
        idx = fl_head;
        steps = 0;
        while (idx != 0 && blk_size[rd_idx(idx)] < want)
        begin
            steps++;
            if (steps > HEAP_UNITS)
            begin
                idx = 0;
                break;
            end
            idx = fl_next[rd_idx(idx)];
        end
        if (idx == 0)
        begin
            r.status = ST_NOSPC;
            r.alloc_offset = '0;
            return r;
        end
        free_list_remove(idx);
        cur = blk_size[rd_idx(idx)];
        if (cur >= want && cur - want >= 2)
        begin
            rest = idx + 1 + want;
            after = idx + 1 + cur;
            blk_size[wr_idx(rest)] = cur - want - 1;
            blk_prev[wr_idx(rest)] = idx;
            blk_size[wr_idx(idx)] = want;
            free_list_insert(rest);
            if (after < heap_end)
                blk_prev[wr_idx(after)] = rest;
        end
        r.status = ST_OK;
        r.alloc_offset = 15'((idx * 8) & 32'h7FFF);
        return r;
    endfunction

    function automatic reply_t coalescing_free(int unsigned off);
        reply_t r;
        int unsigned idx;
        int unsigned nxt;
        int unsigned pv;
        int unsigned after;
        r.alloc_offset = '0;
        if ((off & 7) != 0 || off == 0 || off >= heap_size * 8)
        begin
            r.status = ST_BADADR;
            return r;
        end
        idx = off / 8;
        if (blk_free[rd_idx(idx)])
        begin
            r.status = ST_DBLFRE;
            return r;
        end
        nxt = idx + 1 + blk_size[rd_idx(idx)];
        // Merge with the block below
        if (idx > 1)
        begin
            pv = blk_prev[rd_idx(idx)];
            if (blk_free[rd_idx(pv)])
            begin
                free_list_remove(pv);
                blk_size[wr_idx(pv)] = blk_size[rd_idx(pv)] + 1 + blk_size[rd_idx(idx)];
                if (nxt < heap_end)
                    blk_prev[wr_idx(nxt)] = pv;
                idx = pv;
            end
        end
        // Merge with the block above
        if (nxt < heap_end && blk_free[rd_idx(nxt)])
        begin
            free_list_remove(nxt);
            blk_size[wr_idx(idx)] = blk_size[rd_idx(idx)] + 1 + blk_size[rd_idx(nxt)];
            after = idx + 1 + blk_size[rd_idx(idx)];
            if (after < heap_end)
                blk_prev[wr_idx(after)] = idx;
        end
        free_list_insert(idx);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Response ready with random stall bursts
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            rsp.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end
        else
            rsp.ready <= 1'b1;
    end

    // Compare each transfer against the oldest expectation
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected response, status", rsp.status, -1);
            else
            begin
                e = pending_replies.pop_front();
                if (rsp.status !== e.status)
                    report_mismatch("status", rsp.status, e.status);
                if (rsp.alloc_offset !== e.alloc_offset)
                    report_mismatch("alloc_offset", rsp.alloc_offset, e.alloc_offset);
            end
        end
    end

    // Send one request and record its expected response
    task automatic send_request(input logic cmd, input int unsigned bytes,
                                input int unsigned off);
        reply_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 14)) @(negedge clk);
        @(negedge clk);
        req.valid <= 1'b1;
        req.command <= cmd;
        req.alloc_bytes <= 16'(bytes);
        req.free_offset <= 15'(off);
        do
            @(posedge clk);
        while (!req.ready);
        if (cmd == CMD_ALLOC)
        begin
            r = best_fit_alloc(bytes & 32'hFFFF);
            if (r.status == ST_OK)
                live_offsets.push_back(r.alloc_offset);
        end
        else
            r = coalescing_free(off & 32'h7FFF);
        pending_replies.push_back(r);
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_units(input int unsigned value);
        drain();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= 13'(value);
        do
            @(posedge clk);
        while (!cfg.ready);
        heap_format(value);
        live_offsets.delete();
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic free_live(input int pos);
        int unsigned off;
        off = live_offsets[pos];
        live_offsets.delete(pos);
        send_request(CMD_FREE, 0, off);
    endtask

    // One random request: mostly alloc/free of live blocks, some bad frees
    task automatic random_request(input int unsigned max_bytes);
        int sel;
        int unsigned off;
        sel = $urandom_range(0, 99);
        if (sel < 45 && live_offsets.size() != 0)
            free_live($urandom_range(0, live_offsets.size() - 1));
        else if (sel < 52)
        begin
            case ($urandom_range(0, 2))
                0: off = $urandom_range(0, 32767) | 1;
                1: off = 0;
                default: off = $urandom_range(heap_size * 8 < 32768 ? heap_size * 8 : 32767,
                                              32767) & ~32'h7;
            endcase
            if (off == 0 || off >= heap_size * 8 || (off & 7) != 0)
                send_request(CMD_FREE, $urandom_range(0, 65535), off);
            else
                send_request(CMD_FREE, 0, 32767);
        end
        else if (sel < 56 && fl_head != 0)
            send_request(CMD_FREE, 0, fl_head * 8);
        else if ($urandom_range(0, 19) == 0)
            send_request(CMD_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 32767));
        else
            send_request(CMD_ALLOC, $urandom_range(0, max_bytes), $urandom_range(0, 32767));
    endtask

    task automatic test_directed_alloc;
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_ALLOC, 8, 0);
        send_request(CMD_ALLOC, 9, 0);
        send_request(CMD_ALLOC, 65535, 0);
        send_request(CMD_ALLOC, 32768, 0);
        send_request(CMD_ALLOC, 4000, 0);
    endtask

    task automatic test_directed_free;
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 13);
        send_request(CMD_FREE, 0, 32767);
        send_request(CMD_FREE, 0, 32760);
        // Free out of order so both neighbor merges occur
        free_live(1);
        free_live(2);
        send_request(CMD_FREE, 0, fl_head * 8);
        free_live(0);
        while (live_offsets.size() != 0)
            free_live(0);
    endtask

    task automatic test_smallest_heap;
        write_heap_units(0);
        send_request(CMD_ALLOC, 16, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 16);
        free_live(0);
        send_request(CMD_FREE, 0, 8);
        write_heap_units(2);
        send_request(CMD_ALLOC, 8, 0);
        write_heap_units(3);
        send_request(CMD_ALLOC, 17, 0);
        send_request(CMD_ALLOC, 0, 0);
    endtask

    task automatic test_random_heaps;
        int unsigned sizes [6] = '{8191, 16, 4096, 200, 3, 1000};
        foreach (sizes[k])
        begin
            write_heap_units(sizes[k]);
            repeat (180)
                random_request(sizes[k] < 100 ? 64 : 600);
            // Let every outstanding response arrive before sending more
            drain();
            repeat (20)
                random_request(sizes[k] < 100 ? 64 : 600);
        end
        write_heap_units($urandom_range(4, 8191));
        repeat (100)
            random_request(300);
    endtask

    task automatic test_no_idle;
        quiet = 1'b1;
        write_heap_units(4096);
        repeat (60)
            random_request(2000);
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.command = CMD_ALLOC;
        req.alloc_bytes = '0;
        req.free_offset = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rsp.ready = 1'b1;
        heap_size = HEAP_UNITS;
        for (int i = 0; i <= STORE_LAST; i++)
        begin
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
            blk_prev[i] = 0;
            fl_prev[i] = 0;
            fl_next[i] = 0;
        end
        heap_format(HEAP_UNITS);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_alloc();
        test_directed_free();
        test_smallest_heap();
        test_random_heaps();
        test_no_idle();

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/bfha_pkg.sv
hdl/bfha_if.sv
hdl/bfha_store.sv
hdl/best_fit_heap_allocator.sv
test/best_fit_heap_allocator_test.sv
